### hw/rtl/quaternion_slerp_top_assert.svh
// quaternion_slerp_top_assert.svh: assertion macros for the slerp checker
// clocked on clk_i; the rst variant is disabled while rst_ni is low
`ifndef QUATERNION_SLERP_TOP_ASSERT_SVH
`define QUATERNION_SLERP_TOP_ASSERT_SVH

// plain clocked assertion, checked during reset too
`define QST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

// clocked assertion, disabled during reset
`define QST_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`endif

### hw/rtl/qs_pkg.sv
// qs_pkg: constants and the arctangent table of the quaternion slerp block
// no dependencies
package qs_pkg;

  // weight of one in Q1.16
  localparam logic [16:0] T_ONE = 17'd65536;

  // cordic gain correction in Q30
  localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;

  // pi/2 in Q30
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

  // one in Q30, as a 31 bit weight
  localparam logic [30:0] ONE_Q30 = 31'd1073741824;

  // atan(2^-i) in Q30
  function automatic logic [30:0] atan_q30(input logic [4:0] idx);
    logic [30:0] val;
    unique case (idx)
      5'd0:  val = 31'd843314857;
      5'd1:  val = 31'd497837829;
      5'd2:  val = 31'd263043837;
      5'd3:  val = 31'd133525159;
      5'd4:  val = 31'd67021687;
      5'd5:  val = 31'd33543516;
      5'd6:  val = 31'd16775851;
      5'd7:  val = 31'd8388437;
      5'd8:  val = 31'd4194283;
      5'd9:  val = 31'd2097149;
      5'd10: val = 31'd1048576;
      5'd11: val = 31'd524288;
      5'd12: val = 31'd262144;
      5'd13: val = 31'd131072;
      5'd14: val = 31'd65536;
      5'd15: val = 31'd32768;
      5'd16: val = 31'd16384;
      5'd17: val = 31'd8192;
      5'd18: val = 31'd4096;
      5'd19: val = 31'd2048;
      5'd20: val = 31'd1024;
      5'd21: val = 31'd512;
      5'd22: val = 31'd256;
      5'd23: val = 31'd128;
      5'd24: val = 31'd64;
      5'd25: val = 31'd32;
      5'd26: val = 31'd16;
      5'd27: val = 31'd8;
      5'd28: val = 31'd4;
      5'd29: val = 31'd2;
      5'd30: val = 31'd1;
      5'd31: val = 31'd0;
    endcase
    return val;
  endfunction

endpackage

### hw/rtl/qs_fifo.sv
// qs_fifo: small register queue with full/empty flags
// used between front and back and on the result side; no package use
module qs_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_q, rd_q;
  logic [CW-1:0]    cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_pop  = pop_i && !empty_o;
  // a beat may enter a full queue in the cycle its head leaves
  assign do_push = push_i && (!full_o || pop_i);
  assign data_o  = mem_q[rd_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
      end
      cnt_q <= cnt_q + CW'(do_push) - CW'(do_pop);
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

### hw/rtl/qs_front.sv
// qs_front: takes input beats, forms the 4-d dot product and picks the blend kind
// uses qs_pkg; feeds the queue in front of qs_back
module qs_front #(
  parameter int unsigned COMPONENT_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push_i,
  output logic                             full_o,
  input  logic signed [COMPONENT_BITS-1:0] from_x_i,
  input  logic signed [COMPONENT_BITS-1:0] from_y_i,
  input  logic signed [COMPONENT_BITS-1:0] from_z_i,
  input  logic signed [COMPONENT_BITS-1:0] from_w_i,
  input  logic signed [COMPONENT_BITS-1:0] to_x_i,
  input  logic signed [COMPONENT_BITS-1:0] to_y_i,
  input  logic signed [COMPONENT_BITS-1:0] to_z_i,
  input  logic signed [COMPONENT_BITS-1:0] to_w_i,
  input  logic [16:0]                      blend_weight_i,
  input  logic                             near_threshold_we_i,
  input  logic [13:0]                      near_threshold_i,
  output logic                             q_push_o,
  output logic [8*COMPONENT_BITS+48:0]     q_data_o,
  input  logic                             q_full_i
);

  localparam int unsigned C  = COMPONENT_BITS;
  localparam int unsigned SH = 32 - COMPONENT_BITS;

  logic [13:0]          thr_q;
  logic                 f1_vld_q;
  logic signed [C-1:0]  fr_q [4];
  logic signed [C-1:0]  tv_q [4];
  logic [16:0]          t_q;
  logic signed [33:0]   prod_q [4];

  logic signed [C-1:0]  fr_in [4];
  logic signed [C-1:0]  tv_in [4];
  logic signed [31:0]   fw [4];
  logic signed [31:0]   tw [4];
  logic signed [63:0]   pr [4];
  logic [16:0]          t_clamp;
  logic                 fe;
  logic signed [35:0]   dot, dabs;
  logic signed [36:0]   gap, thr_wide;
  logic                 neg, lin;

  assign fr_in[0] = from_x_i;
  assign fr_in[1] = from_y_i;
  assign fr_in[2] = from_z_i;
  assign fr_in[3] = from_w_i;
  assign tv_in[0] = to_x_i;
  assign tv_in[1] = to_y_i;
  assign tv_in[2] = to_z_i;
  assign tv_in[3] = to_w_i;

  // stage advances unless its beat cannot leave
  assign fe     = !(f1_vld_q && q_full_i);
  assign full_o = !fe;

  // threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= 14'd1;
    end else if (near_threshold_we_i) begin
      thr_q <= near_threshold_i;
    end
  end

  // widen to q30 and multiply, products rounded down to q30
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      fw[k] = 32'(fr_in[k]) <<< SH;
      tw[k] = 32'(tv_in[k]) <<< SH;
      pr[k] = 64'(fw[k]) * 64'(tw[k]);
    end
  end

  assign t_clamp = (blend_weight_i > qs_pkg::T_ONE) ? qs_pkg::T_ONE : blend_weight_i;

  // input stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_vld_q <= 1'b0;
    end else if (fe) begin
      f1_vld_q <= push_i;
    end
  end

  // input stage payload
  always_ff @(posedge clk_i) begin
    if (fe && push_i) begin
      for (int k = 0; k < 4; k++) begin
        fr_q[k]   <= fr_in[k];
        tv_q[k]   <= tv_in[k];
        prod_q[k] <= pr[k][63:30];
      end
      t_q <= t_clamp;
    end
  end

  // dot sum, shorter arc and near test
  always_comb begin
    dot      = 36'(prod_q[0]) + 36'(prod_q[1]) + 36'(prod_q[2]) + 36'(prod_q[3]);
    neg      = dot[35];
    dabs     = neg ? -dot : dot;
    gap      = (37'sd1 <<< 30) - 37'(dabs);
    thr_wide = $signed({7'd0, thr_q, 16'd0});
    lin      = !(gap > thr_wide);
  end

  assign q_push_o = f1_vld_q && !q_full_i;
  assign q_data_o = {fr_q[0], fr_q[1], fr_q[2], fr_q[3],
                     tv_q[0], tv_q[1], tv_q[2], tv_q[3],
                     neg, t_q, lin, dabs[29:0]};

endmodule

### hw/rtl/qs_back.sv
// qs_back: slerp datapath pipeline: sqrt, cordic angle, cordic sines, divide, blend
// uses qs_pkg; reads the front queue and writes the result queue
module qs_back #(
  parameter int unsigned COMPONENT_BITS = 16,
  parameter int unsigned CORDIC_STEPS   = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           q_empty_i,
  input  logic [8*COMPONENT_BITS+48:0]   q_data_i,
  output logic                           q_pop_o,
  input  logic                           of_full_i,
  input  logic                           pop_i,
  output logic                           of_push_o,
  output logic [4*COMPONENT_BITS-1:0]    of_data_o
);

  localparam int unsigned C      = COMPONENT_BITS;
  localparam int unsigned N      = CORDIC_STEPS;
  localparam int unsigned QW     = 8 * C + 49;
  localparam int unsigned SW     = 8 * C + 19;
  localparam int unsigned SH     = 32 - C;
  localparam int unsigned RS     = 62 - C;
  localparam int unsigned J_SQL  = 32;
  localparam int unsigned J_VECL = 32 + N;
  localparam int unsigned J_DIVL = 64 + 2 * N;
  localparam int unsigned LT     = 66 + 2 * N;
  localparam logic signed [65:0] RND = 66'sd1 <<< (RS - 1);
  localparam logic signed [65:0] HI  = (66'sd1 <<< (C - 1)) - 66'sd1;
  localparam logic signed [65:0] LO  = -HI - 66'sd1;

  logic              ba;
  logic [LT-1:0]     vld_q;
  logic [SW-1:0]     side_q [J_DIVL+1];

  logic [59:0]       dsq_q;
  logic [29:0]       d0_q;
  logic [63:0]       sv_q [32];
  logic [63:0]       sr_q [32];
  logic [29:0]       sd_q [32];

  logic signed [33:0] vx_q [N];
  logic signed [33:0] vy_q [N];
  logic signed [32:0] vz_q [N];
  logic [30:0]        vsw_q [N];

  logic [30:0]        a_q [2];
  logic [30:0]        asw_q;
  logic [30:0]        ang;
  logic [16:0]        t_ang, tm_ang;
  logic [47:0]        ap0, ap1;

  logic signed [33:0] rx_q [2][N];
  logic signed [33:0] ry_q [2][N];
  logic signed [32:0] rz_q [2][N];
  logic [30:0]        rsw_q [N];

  logic [30:0]        pr_q [2];
  logic               pz_q [2];
  logic               ps_q [2];
  logic [30:0]        psw_q;

  logic [30:0]        dr_q [2][30];
  logic [29:0]        quot_q [2][30];
  logic               dz_q [2][30];
  logic               ds_q [2][30];
  logic [30:0]        dsw_q [30];

  logic signed [63:0] m0_q [4];
  logic signed [64:0] m1_q [4];

  logic [SW-1:0]      sl;
  logic [30:0]        wl [2];
  logic [30:0]        w0, w1;
  logic signed [31:0] ws0, ws1;
  logic signed [31:0] fw [4];
  logic signed [31:0] tw [4];
  logic signed [32:0] tn [4];
  logic signed [65:0] acc [4];
  logic signed [65:0] shv [4];
  logic [C-1:0]       res [4];

  // whole pipeline moves unless the result queue is full and not drained
  assign ba       = !of_full_i || pop_i;
  assign q_pop_o  = ba && !q_empty_i;

  // valid line
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ba) begin
      vld_q <= {vld_q[LT-2:0], !q_empty_i};
    end
  end

  // operands, weight and flags ride along
  always_ff @(posedge clk_i) begin
    if (ba) begin
      side_q[0] <= q_data_i[QW-1:30];
      for (int j = 1; j <= J_DIVL; j++) begin
        side_q[j] <= side_q[j-1];
      end
    end
  end

  // square of the dot
  always_ff @(posedge clk_i) begin
    if (ba) begin
      dsq_q <= 60'(q_data_i[29:0]) * 60'(q_data_i[29:0]);
      d0_q  <= q_data_i[29:0];
    end
  end

  // integer square root of one minus dot squared, one result bit per stage
  for (genvar k = 0; k < 32; k++) begin : g_sqrt
    localparam logic [63:0] BITV = 64'd1 << (62 - 2 * k);
    logic [63:0] v_in, r_in, sum;
    logic [29:0] d_in;
    if (k == 0) begin : g_first
      assign v_in = (64'd1 << 60) - 64'(dsq_q);
      assign r_in = '0;
      assign d_in = d0_q;
    end else begin : g_next
      assign v_in = sv_q[k-1];
      assign r_in = sr_q[k-1];
      assign d_in = sd_q[k-1];
    end
    assign sum = r_in + BITV;
    always_ff @(posedge clk_i) begin
      if (ba) begin
        if (v_in >= sum) begin
          sv_q[k] <= v_in - sum;
          sr_q[k] <= (r_in >> 1) + BITV;
        end else begin
          sv_q[k] <= v_in;
          sr_q[k] <= r_in >> 1;
        end
        sd_q[k] <= d_in;
      end
    end
  end

  // vectoring cordic: angle of (dot, sin w)
  for (genvar i = 0; i < N; i++) begin : g_vec
    logic signed [33:0] x_in, y_in, dx, dy;
    logic signed [32:0] z_in, at;
    logic [30:0]        sw_in;
    if (i == 0) begin : g_first
      assign x_in  = {4'd0, sd_q[J_SQL-1]};
      assign y_in  = {3'd0, sr_q[J_SQL-1][30:0]};
      assign z_in  = '0;
      assign sw_in = sr_q[J_SQL-1][30:0];
    end else begin : g_next
      assign x_in  = vx_q[i-1];
      assign y_in  = vy_q[i-1];
      assign z_in  = vz_q[i-1];
      assign sw_in = vsw_q[i-1];
    end
    assign at = {2'd0, qs_pkg::atan_q30(5'(i))};
    assign dx = y_in >>> i;
    assign dy = x_in >>> i;
    always_ff @(posedge clk_i) begin
      if (ba) begin
        if (!y_in[33]) begin
          vx_q[i] <= x_in + dx;
          vy_q[i] <= y_in - dy;
          vz_q[i] <= z_in + at;
        end else begin
          vx_q[i] <= x_in - dx;
          vy_q[i] <= y_in + dy;
          vz_q[i] <= z_in - at;
        end
        vsw_q[i] <= sw_in;
      end
    end
  end

  // clamp the angle to [0, pi/2] and split it by the weight
  always_comb begin
    priority if (vz_q[N-1][32]) begin
      ang = '0;
    end else if (vz_q[N-1][31:0] > {1'b0, qs_pkg::HALF_PI_Q30}) begin
      ang = qs_pkg::HALF_PI_Q30;
    end else begin
      ang = vz_q[N-1][30:0];
    end
    t_ang  = side_q[J_VECL][17:1];
    tm_ang = qs_pkg::T_ONE - t_ang;
    ap0    = 48'(ang) * 48'(tm_ang);
    ap1    = 48'(ang) * 48'(t_ang);
  end

  always_ff @(posedge clk_i) begin
    if (ba) begin
      a_q[0] <= ap0[46:16];
      a_q[1] <= ap1[46:16];
      asw_q  <= vsw_q[N-1];
    end
  end

  // sin w carried beside the rotation lanes
  for (genvar i = 0; i < N; i++) begin : g_rsw
    always_ff @(posedge clk_i) begin
      if (ba) begin
        rsw_q[i] <= (i == 0) ? asw_q : rsw_q[(i == 0) ? 0 : i-1];
      end
    end
  end

  // two rotation cordic lanes: sin((1-t)w) and sin(tw)
  for (genvar l = 0; l < 2; l++) begin : g_lane
    for (genvar i = 0; i < N; i++) begin : g_rot
      logic signed [33:0] x_in, y_in, dx, dy;
      logic signed [32:0] z_in, at;
      if (i == 0) begin : g_first
        assign x_in = qs_pkg::GAIN_Q30;
        assign y_in = '0;
        assign z_in = {2'd0, a_q[l]};
      end else begin : g_next
        assign x_in = rx_q[l][i-1];
        assign y_in = ry_q[l][i-1];
        assign z_in = rz_q[l][i-1];
      end
      assign at = {2'd0, qs_pkg::atan_q30(5'(i))};
      assign dx = y_in >>> i;
      assign dy = x_in >>> i;
      always_ff @(posedge clk_i) begin
        if (ba) begin
          if (!z_in[32]) begin
            rx_q[l][i] <= x_in - dx;
            ry_q[l][i] <= y_in + dy;
            rz_q[l][i] <= z_in - at;
          end else begin
            rx_q[l][i] <= x_in + dx;
            ry_q[l][i] <= y_in - dy;
            rz_q[l][i] <= z_in + at;
          end
        end
      end
    end

    // ratio bounds: nonpositive sine gives zero, sine at or above sin w gives one
    logic signed [33:0] s;
    logic               zf, sf;
    assign s  = ry_q[l][N-1];
    assign zf = s[33] || (s == '0);
    assign sf = !zf && (s[32:0] >= {2'd0, rsw_q[N-1]});
    always_ff @(posedge clk_i) begin
      if (ba) begin
        pr_q[l] <= s[30:0];
        pz_q[l] <= zf;
        ps_q[l] <= sf;
      end
    end

    // restoring divide, one quotient bit per stage
    for (genvar i = 0; i < 30; i++) begin : g_div
      logic [30:0] r_in, sw_in;
      logic [29:0] q_in;
      logic        z_in, s_in, ge;
      logic [31:0] r2;
      if (i == 0) begin : g_first
        assign r_in  = pr_q[l];
        assign q_in  = '0;
        assign z_in  = pz_q[l];
        assign s_in  = ps_q[l];
        assign sw_in = psw_q;
      end else begin : g_next
        assign r_in  = dr_q[l][i-1];
        assign q_in  = quot_q[l][i-1];
        assign z_in  = dz_q[l][i-1];
        assign s_in  = ds_q[l][i-1];
        assign sw_in = dsw_q[i-1];
      end
      assign r2 = {r_in, 1'b0};
      assign ge = (r2 >= {1'b0, sw_in});
      always_ff @(posedge clk_i) begin
        if (ba) begin
          dr_q[l][i]   <= ge ? 31'(r2 - {1'b0, sw_in}) : r2[30:0];
          quot_q[l][i] <= {q_in[28:0], ge};
          dz_q[l][i]   <= z_in;
          ds_q[l][i]   <= s_in;
        end
      end
    end

    // clamped slerp weight in q30
    always_comb begin
      priority if (dz_q[l][29]) begin
        wl[l] = '0;
      end else if (ds_q[l][29]) begin
        wl[l] = qs_pkg::ONE_Q30;
      end else begin
        wl[l] = {1'b0, quot_q[l][29]};
      end
    end
  end

  // sin w beside the divider
  always_ff @(posedge clk_i) begin
    if (ba) begin
      psw_q    <= rsw_q[N-1];
      dsw_q[0] <= psw_q;
      for (int i = 1; i < 30; i++) begin
        dsw_q[i] <= dsw_q[i-1];
      end
    end
  end

  // pick weights and form the eight weighted components
  always_comb begin
    sl  = side_q[J_DIVL];
    w0  = sl[0] ? {qs_pkg::T_ONE - sl[17:1], 14'd0} : wl[0];
    w1  = sl[0] ? {sl[17:1], 14'd0} : wl[1];
    ws0 = $signed({1'b0, w0});
    ws1 = $signed({1'b0, w1});
    for (int k = 0; k < 4; k++) begin
      fw[k] = 32'($signed(sl[SW-1-k*C -: C])) <<< SH;
      tw[k] = 32'($signed(sl[SW-1-(4+k)*C -: C])) <<< SH;
      tn[k] = sl[18] ? -33'(tw[k]) : 33'(tw[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ba) begin
      for (int k = 0; k < 4; k++) begin
        m0_q[k] <= 64'(ws0) * 64'(fw[k]);
        m1_q[k] <= 65'(ws1) * 65'(tn[k]);
      end
    end
  end

  // sum, round half up and saturate
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      acc[k] = 66'(m0_q[k]) + 66'(m1_q[k]) + RND;
      shv[k] = acc[k] >>> RS;
      priority if (shv[k] > HI) begin
        res[k] = HI[C-1:0];
      end else if (shv[k] < LO) begin
        res[k] = LO[C-1:0];
      end else begin
        res[k] = shv[k][C-1:0];
      end
    end
  end

  assign of_push_o = ba && vld_q[LT-1];
  assign of_data_o = {res[0], res[1], res[2], res[3]};

endmodule

### hw/rtl/quaternion_slerp_top.sv
// quaternion_slerp_top: fixed point quaternion slerp with queue-style ports
// uses qs_pkg, qs_fifo, qs_front and qs_back
//
// channel   direction  handshake            beat
// input     in         push_i / full_o      from_*_i, to_*_i, blend_weight_i
// result    out        pop_i / empty_o      out_x_o .. out_w_o
// config    in         near_threshold_we_i  near_threshold_i
//
// one item accepted per cycle while full_o is low
// the back pipeline runs the 32 stage square root, the two cordic runs and the 30 stage divide
// reset clears all valid flags and sets near_threshold to 1; no clearing pass
// a held result stalls the back pipeline, and the front stalls once its queue fills
module quaternion_slerp_top #(
  parameter int unsigned COMPONENT_BITS = 16,
  parameter int unsigned CORDIC_STEPS   = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push_i,
  output logic                             full_o,
  input  logic signed [COMPONENT_BITS-1:0] from_x_i,
  input  logic signed [COMPONENT_BITS-1:0] from_y_i,
  input  logic signed [COMPONENT_BITS-1:0] from_z_i,
  input  logic signed [COMPONENT_BITS-1:0] from_w_i,
  input  logic signed [COMPONENT_BITS-1:0] to_x_i,
  input  logic signed [COMPONENT_BITS-1:0] to_y_i,
  input  logic signed [COMPONENT_BITS-1:0] to_z_i,
  input  logic signed [COMPONENT_BITS-1:0] to_w_i,
  input  logic [16:0]                      blend_weight_i,
  input  logic                             near_threshold_we_i,
  input  logic [13:0]                      near_threshold_i,
  output logic                             empty_o,
  input  logic                             pop_i,
  output logic signed [COMPONENT_BITS-1:0] out_x_o,
  output logic signed [COMPONENT_BITS-1:0] out_y_o,
  output logic signed [COMPONENT_BITS-1:0] out_z_o,
  output logic signed [COMPONENT_BITS-1:0] out_w_o
);

  localparam int unsigned C  = COMPONENT_BITS;
  localparam int unsigned QW = 8 * C + 49;

  logic          mq_push, mq_full, mq_pop, mq_empty;
  logic [QW-1:0] mq_wdata, mq_rdata;
  logic          of_push, of_full;
  logic [4*C-1:0] of_wdata, of_rdata;

  // front: accept and classify
  qs_front #(
    .COMPONENT_BITS(COMPONENT_BITS)
  ) u_front (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .push_i              (push_i),
    .full_o              (full_o),
    .from_x_i            (from_x_i),
    .from_y_i            (from_y_i),
    .from_z_i            (from_z_i),
    .from_w_i            (from_w_i),
    .to_x_i              (to_x_i),
    .to_y_i              (to_y_i),
    .to_z_i              (to_z_i),
    .to_w_i              (to_w_i),
    .blend_weight_i      (blend_weight_i),
    .near_threshold_we_i (near_threshold_we_i),
    .near_threshold_i    (near_threshold_i),
    .q_push_o            (mq_push),
    .q_data_o            (mq_wdata),
    .q_full_i            (mq_full)
  );

  // queue between front and back
  qs_fifo #(
    .WIDTH(QW),
    .DEPTH(2)
  ) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mq_push),
    .data_i  (mq_wdata),
    .full_o  (mq_full),
    .pop_i   (mq_pop),
    .data_o  (mq_rdata),
    .empty_o (mq_empty)
  );

  // back: slerp datapath
  qs_back #(
    .COMPONENT_BITS(COMPONENT_BITS),
    .CORDIC_STEPS  (CORDIC_STEPS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (mq_empty),
    .q_data_i  (mq_rdata),
    .q_pop_o   (mq_pop),
    .of_full_i (of_full),
    .pop_i     (pop_i),
    .of_push_o (of_push),
    .of_data_o (of_wdata)
  );

  // result queue
  qs_fifo #(
    .WIDTH(4 * C),
    .DEPTH(2)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (of_push),
    .data_i  (of_wdata),
    .full_o  (of_full),
    .pop_i   (pop_i),
    .data_o  (of_rdata),
    .empty_o (empty_o)
  );

  assign out_x_o = of_rdata[4*C-1 -: C];
  assign out_y_o = of_rdata[3*C-1 -: C];
  assign out_z_o = of_rdata[2*C-1 -: C];
  assign out_w_o = of_rdata[C-1:0];

endmodule

### hw/rtl/qs_checker.sv
// qs_checker: port-level checks for quaternion_slerp_top, bound to the top level
// uses the macros of quaternion_slerp_top_assert.svh
`include "quaternion_slerp_top_assert.svh"

module qs_checker #(
  parameter int unsigned COMPONENT_BITS = 16
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             full_o,
  input logic                             empty_o,
  input logic                             pop_i,
  input logic signed [COMPONENT_BITS-1:0] out_x_o,
  input logic signed [COMPONENT_BITS-1:0] out_w_o
);

  // reset empties the result side and opens the input side
  `QST_ASSERT(a_rst_empty, !rst_ni |-> empty_o, "result shown during reset")
  `QST_ASSERT(a_rst_open, !rst_ni |-> !full_o, "input blocked during reset")

  // a result cannot reach the result queue straight out of reset, so empty_o still holds
  `QST_ASSERT(a_no_early_result, $past(!rst_ni, 3) |-> empty_o, "result too soon after reset")

  // a waiting result holds until taken
  `QST_ASSERT_RST(a_result_hold, (!empty_o && !pop_i) |=> (!empty_o && $stable(out_x_o) && $stable(out_w_o)), "waiting result changed")

endmodule

bind quaternion_slerp_top qs_checker #(
  .COMPONENT_BITS(COMPONENT_BITS)
) u_qs_checker (.*);
